FILE: design/mdt_pkg.sv
// ----------------------------------------------------------------------------
// mdt_pkg: shared types and constants for the depfile tokenizer
// Character codes, phase and status codes, the result word and the
// architectural state record.
// ----------------------------------------------------------------------------
`default_nettype none

package mdt_pkg;

  // Most result words one input byte can cause
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned RdW    = $clog2(MaxRes);

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic {
    PH_SEEK,
    PH_SCAN
  } mdt_phase_e;

  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_OK       = 2'd1,
    ST_NO_COLON = 2'd2
  } mdt_status_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        token_end;
    mdt_status_e status;
    logic        last_of_run;
  } mdt_res_t;

  typedef struct packed {
    mdt_phase_e  phase;
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [1:0]  held_cnt;
    logic        in_name;
    logic        stopped;
  } mdt_state_t;

endpackage

`default_nettype wire

FILE: design/mdt_if.sv
// ----------------------------------------------------------------------------
// mdt_in_if / mdt_out_if: valid/ready channels of the depfile tokenizer
// Input channel carries text bytes, output channel carries result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface mdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       token_end;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output has_byte, output token_end,
                  output status, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input token_end,
                  input status, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: design/make_depfile_tokenizer.sv
// ----------------------------------------------------------------------------
// make_depfile_tokenizer: prerequisite tokenizer for make-style depfiles
// Skips the target up to the first colon followed by whitespace, then emits
// prerequisite name bytes and name-end marks.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one text word per handshake (in_byte, is_last). A zero byte or
//           is_last ends the text; afterwards words are taken and dropped
//           until reset.
//   out_o : result words (out_byte/has_byte, token_end, status, last_of_run).
//           Each input word causes 0 to 3 result words; last_of_run flags the
//           final one, status is set only on the final word of the text.
// Latency: the first result of a word is valid the cycle after acceptance.
// Throughput: one input word per cycle while each causes at most one result
//   and out_o.ready is high; a word with more results holds the input until
//   the single result register has drained it, one word per handshake.
// Up to two bytes are held as lookahead inside the state register.
// Reset: seek-colon phase, no held bytes, output empty.
// Stall: while out_o.ready is low the current result holds and in_i.ready
//   is low as long as any result word is held.
// ----------------------------------------------------------------------------
`default_nettype none

module make_depfile_tokenizer import mdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mdt_in_if.sink    in_i,
  mdt_out_if.source out_o
);

  mdt_state_t            state_q;
  mdt_state_t            state_d;
  mdt_res_t [MaxRes-1:0] step_res;
  logic [CntW-1:0]       step_cnt;
  logic                  can_load;
  logic                  in_fire;
  logic                  ends;

  assign in_i.ready = can_load;
  assign in_fire    = in_i.valid && in_i.ready;
  assign ends       = (in_i.in_byte == CH_NUL) || in_i.is_last;

  mdt_step u_step (
    .state_i   (state_q),
    .in_byte_i (in_i.in_byte),
    .is_last_i (in_i.is_last),
    .state_o   (state_d),
    .res_o     (step_res),
    .cnt_o     (step_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_SEEK, held0: 8'h00, held1: 8'h00, held_cnt: 2'd0,
                   in_name: 1'b0, stopped: 1'b0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  mdt_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .res_i      (step_res),
    .cnt_i      (step_cnt),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  // stopped block swallows words silently
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.stopped) |-> (step_cnt == '0))
    else $error("results produced after end of text");

  // end of text always yields at least the status word
  a_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !state_q.stopped && ends) |-> (step_cnt != '0))
    else $error("end of text produced no result");

  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ends) |=> state_q.stopped)
    else $error("block did not stop after end of text");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q.held_cnt != 2'd3))
    else $error("held byte count out of range");

endmodule

`default_nettype wire

FILE: design/mdt_step.sv
// ----------------------------------------------------------------------------
// mdt_step: next-state and result logic for one text byte
// Builds the lookahead window from the held bytes and the new byte, decides
// up to three window positions in sequence and gathers the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_step import mdt_pkg::*; (
  input  mdt_state_t                state_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      is_last_i,
  output mdt_state_t                state_o,
  output mdt_res_t [MaxRes-1:0]     res_o,
  output logic [CntW-1:0]           cnt_o
);

  typedef struct packed {
    logic [1:0] used;
    logic       emit;
    logic       has;
    logic [7:0] byte_v;
    logic       tend;
    mdt_phase_e phase;
    logic       in_name;
  } dec_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic mdt_res_t mk_res(logic has, logic [7:0] b, logic tend);
    mdt_res_t r;
    r             = '0;
    r.out_byte    = has ? b : 8'h00;
    r.has_byte    = has;
    r.token_end   = tend;
    r.status      = ST_RUN;
    return r;
  endfunction

  // Decide one byte; used == 0 means more lookahead is needed
  function automatic dec_t decide(mdt_phase_e ph, logic inn, logic [7:0] b0,
                                  logic [7:0] b1, logic k1, logic [7:0] b2, logic k2);
    dec_t d;
    logic n;
    logic done;
    d         = '0;
    d.phase   = ph;
    d.in_name = inn;
    n         = inn;
    done      = 1'b0;
    if (ph == PH_SEEK) begin
      if (b0 != CH_COLON) begin
        d.used = 2'd1;
      end else if (k1) begin
        d.used = 2'd1;
        if (is_ws(b1)) begin
          d.phase   = PH_SCAN;
          d.in_name = 1'b0;
        end
      end
    end else begin
      if (!n) begin
        if (is_ws(b0)) begin
          d.used = 2'd1;
          done   = 1'b1;
        end else if (b0 == CH_BSLASH) begin
          if (!k1) begin
            done = 1'b1;
          end else if (b1 == CH_LF) begin
            d.used = 2'd2;
            done   = 1'b1;
          end else if (b1 == CH_CR) begin
            if (!k2) begin
              done = 1'b1;
            end else if (b2 == CH_LF) begin
              d.used = 2'd3;
              done   = 1'b1;
            end
          end
        end
        if (!done) n = 1'b1;
      end
      if (!done) begin
        if (is_ws(b0)) begin
          d.emit = 1'b1; d.tend = 1'b1; n = 1'b0; d.used = 2'd1;
        end else if (b0 == CH_BSLASH) begin
          if (!k1) begin
            d.used = 2'd0;
          end else if (b1 == CH_NUL) begin
            // backslash right before end of text is a plain name byte
            d.emit = 1'b1; d.has = 1'b1; d.byte_v = CH_BSLASH; d.used = 2'd1;
          end else if (b1 == CH_LF) begin
            d.emit = 1'b1; d.tend = 1'b1; n = 1'b0; d.used = 2'd2;
          end else if (((b1 == CH_CR) || (b1 == CH_DOLLAR)) && !k2) begin
            d.used = 2'd0;
          end else if ((b1 == CH_CR) && (b2 == CH_LF)) begin
            d.emit = 1'b1; d.tend = 1'b1; n = 1'b0; d.used = 2'd3;
          end else if ((b1 == CH_DOLLAR) && (b2 == CH_DOLLAR)) begin
            d.emit = 1'b1; d.has = 1'b1; d.byte_v = CH_DOLLAR; d.used = 2'd3;
          end else begin
            d.emit = 1'b1; d.has = 1'b1; d.byte_v = b1; d.used = 2'd2;
          end
        end else if (b0 == CH_DOLLAR) begin
          if (k1) begin
            d.emit   = 1'b1;
            d.has    = 1'b1;
            d.byte_v = CH_DOLLAR;
            d.used   = (b1 == CH_DOLLAR) ? 2'd2 : 2'd1;
          end
        end else begin
          d.emit = 1'b1; d.has = 1'b1; d.byte_v = b0; d.used = 2'd1;
        end
      end
      d.in_name = n;
    end
    return d;
  endfunction

  logic [7:0]      w   [4];
  logic [7:0]      lw  [8];
  logic [7:0]      lk;
  logic [1:0]      hc;
  logic [2:0]      wn;
  logic            wend;
  logic [2:0]      pos;
  logic [2:0]      p1;
  logic [2:0]      p2;
  logic [2:0]      rem;
  logic            brk;
  mdt_phase_e      ph;
  logic            inn;
  dec_t            d;
  logic [CntW-1:0] cnt;
  mdt_res_t [MaxRes-1:0] res;
  mdt_status_e     st;

  always_comb begin
    w[0] = state_i.held0;
    w[1] = state_i.held1;
    w[2] = 8'h00;
    w[3] = 8'h00;
    hc   = (state_i.held_cnt > 2'd2) ? 2'd2 : state_i.held_cnt;
    wn   = {1'b0, hc};
    if (in_byte_i != CH_NUL) begin
      w[hc] = in_byte_i;
      wn    = {1'b0, hc} + 3'd1;
    end
    wend = (in_byte_i == CH_NUL) || is_last_i;

    // window with end-of-text lookahead: known past the end reads as zero
    for (int j = 0; j < 8; j++) begin
      lw[j] = ((j < 4) && (3'(j) < wn)) ? w[j[1:0]] : 8'h00;
      lk[j] = (3'(j) < wn) || wend;
    end

    ph   = state_i.phase;
    inn  = state_i.in_name;
    pos  = 3'd0;
    brk  = 1'b0;
    cnt  = '0;
    res  = '0;
    p1   = 3'd0;
    p2   = 3'd0;
    d    = '0;

    for (int i = 0; i < 3; i++) begin
      if (!brk && (pos < wn)) begin
        p1 = pos + 3'd1;
        p2 = pos + 3'd2;
        d  = decide(ph, inn, w[pos[1:0]], lw[p1], lk[p1], lw[p2], lk[p2]);
        ph  = d.phase;
        inn = d.in_name;
        if (d.emit && (cnt < CntW'(MaxRes))) begin
          res[cnt[RdW-1:0]] = mk_res(d.has, d.byte_v, d.tend);
          cnt = cnt + 1'b1;
        end
        if (d.used == 2'd0) begin
          brk = 1'b1;
        end else begin
          pos = pos + {1'b0, d.used};
          if (pos > wn) pos = wn;
        end
      end
    end

    state_o          = state_i;
    state_o.phase    = ph;
    state_o.in_name  = inn;
    rem              = wn - pos;
    state_o.held_cnt = (rem > 3'd2) ? 2'd2 : rem[1:0];
    state_o.held0    = (rem > 3'd0) ? lw[pos] : 8'h00;
    state_o.held1    = (rem > 3'd1) ? lw[pos + 3'd1] : 8'h00;

    st = ST_OK;
    if (wend) begin
      if (ph == PH_SEEK) begin
        st = ST_NO_COLON;
      end else if (inn && (cnt < CntW'(MaxRes))) begin
        res[cnt[RdW-1:0]] = mk_res(1'b0, 8'h00, 1'b1);
        cnt = cnt + 1'b1;
      end
      if (cnt == '0) begin
        res[0] = mk_res(1'b0, 8'h00, 1'b0);
        cnt    = CntW'(1);
      end
      res[RdW'(cnt - 1'b1)].status = st;
      state_o.in_name  = 1'b0;
      state_o.stopped  = 1'b1;
      state_o.held_cnt = 2'd0;
      state_o.held0    = 8'h00;
      state_o.held1    = 8'h00;
    end
    if (cnt != '0) res[RdW'(cnt - 1'b1)].last_of_run = 1'b1;

    // once stopped, bytes are swallowed without effect
    if (state_i.stopped) begin
      state_o = state_i;
      cnt     = '0;
    end
    res_o = res;
    cnt_o = cnt;
  end

endmodule

`default_nettype wire

FILE: design/mdt_outq.sv
// ----------------------------------------------------------------------------
// mdt_outq: result register and serializer
// Holds the result words of one input byte and hands them out one per
// output handshake; reloads in the cycle the last word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module mdt_outq import mdt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  mdt_res_t [MaxRes-1:0] res_i,
  input  logic [CntW-1:0]       cnt_i,
  output logic                  can_load_o,
  mdt_out_if.source             out_o
);

  mdt_res_t [MaxRes-1:0] res_q;
  logic [RdW-1:0]        rd_q;
  logic [CntW-1:0]       remain_q;
  logic                  fire;
  mdt_res_t              cur;

  assign fire       = out_o.valid && out_o.ready;
  assign can_load_o = (remain_q == '0) || ((remain_q == CntW'(1)) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q     <= '0;
      remain_q <= '0;
    end else if (load_i) begin
      rd_q     <= '0;
      remain_q <= cnt_i;
    end else if (fire) begin
      rd_q     <= rd_q + 1'b1;
      remain_q <= remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign cur               = res_q[rd_q];
  assign out_o.valid       = (remain_q != '0);
  assign out_o.out_byte    = cur.out_byte;
  assign out_o.has_byte    = cur.has_byte;
  assign out_o.token_end   = cur.token_end;
  assign out_o.status      = cur.status;
  assign out_o.last_of_run = cur.last_of_run;

endmodule

`default_nettype wire
